>>> hdl/wsfs_pkg.sv
`timescale 1ns / 1ps
package wsfs_pkg;

   localparam int HDR_MAX_BYTES   = 14;
   localparam int STEP_W          = $clog2(HDR_MAX_BYTES);
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic       REQ_HEADER  = 1'b0;
   localparam logic       REQ_PAYLOAD = 1'b1;
   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;

   typedef logic [HDR_MAX_BYTES-1:0][7:0] byte_run_type;

   typedef struct packed {
      byte_run_type      bytes;
      logic [STEP_W-1:0] last_idx;
      logic              frame_end;
   } wsfs_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } wsfs_queue_status_type;

endpackage

>>> hdl/wsfs_front.sv
`timescale 1ns / 1ps
module wsfs_front
   import wsfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_type,
   input  logic                  req_fin_bit,
   input  logic [2:0]            req_rsv_bits,
   input  logic [3:0]            req_frame_opcode,
   input  logic [6:0]            req_length_code,
   input  logic                  req_mask_enable,
   input  logic [31:0]           req_mask_key,
   input  logic [63:0]           req_payload_length,
   input  logic [7:0]            req_payload_byte,
   input  logic                  req_payload_last,
   input  wsfs_queue_status_type q_status,
   output logic                  push,
   output wsfs_entry_type        push_entry
);

   logic [31:0] held_key_ff, held_key_in;
   logic [1:0]  key_idx_ff, key_idx_in;
   logic        masking_on_ff, masking_on_in;
   logic        accept;
   logic [7:0]  key_sel;
   logic [3:0]  ext_n;
   logic [63:0] plen;
   logic [31:0] key;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign push      = accept;
   assign plen      = req_payload_length;
   assign key       = req_mask_key;

   always_comb begin
      case (key_idx_ff)
         2'd0:    key_sel = held_key_ff[31:24];
         2'd1:    key_sel = held_key_ff[23:16];
         2'd2:    key_sel = held_key_ff[15:8];
         default: key_sel = held_key_ff[7:0];
      endcase
   end

   always_comb begin
      push_entry = '0;
      ext_n      = 4'd0;
      if (req_type == REQ_HEADER) begin
         push_entry.bytes[0] = {req_fin_bit, req_rsv_bits, req_frame_opcode};
         push_entry.bytes[1] = {req_mask_enable, req_length_code};
         case (req_length_code)
            LEN_CODE_16: begin
               ext_n = 4'd2;
               push_entry.bytes[2] = plen[15:8];
               push_entry.bytes[3] = plen[7:0];
               push_entry.bytes[4] = key[31:24];
               push_entry.bytes[5] = key[23:16];
               push_entry.bytes[6] = key[15:8];
               push_entry.bytes[7] = key[7:0];
            end
            LEN_CODE_64: begin
               ext_n = 4'd8;
               push_entry.bytes[2]  = plen[63:56];
               push_entry.bytes[3]  = plen[55:48];
               push_entry.bytes[4]  = plen[47:40];
               push_entry.bytes[5]  = plen[39:32];
               push_entry.bytes[6]  = plen[31:24];
               push_entry.bytes[7]  = plen[23:16];
               push_entry.bytes[8]  = plen[15:8];
               push_entry.bytes[9]  = plen[7:0];
               push_entry.bytes[10] = key[31:24];
               push_entry.bytes[11] = key[23:16];
               push_entry.bytes[12] = key[15:8];
               push_entry.bytes[13] = key[7:0];
            end
            default: begin
               ext_n = 4'd0;
               push_entry.bytes[2] = key[31:24];
               push_entry.bytes[3] = key[23:16];
               push_entry.bytes[4] = key[15:8];
               push_entry.bytes[5] = key[7:0];
            end
         endcase
         push_entry.last_idx  = STEP_W'(4'd1 + ext_n + (req_mask_enable ? 4'd4 : 4'd0));
         push_entry.frame_end = 1'b0;
      end else begin
         push_entry.bytes[0]  = masking_on_ff ? (req_payload_byte ^ key_sel) : req_payload_byte;
         push_entry.last_idx  = '0;
         push_entry.frame_end = req_payload_last;
      end
   end

   always_comb begin
      held_key_in   = held_key_ff;
      key_idx_in    = key_idx_ff;
      masking_on_in = masking_on_ff;
      if (accept) begin
         if (req_type == REQ_HEADER) begin
            held_key_in   = req_mask_key;
            key_idx_in    = 2'd0;
            masking_on_in = req_mask_enable;
         end else if (masking_on_ff) begin
            key_idx_in = key_idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_key_ff   <= '0;
         key_idx_ff    <= '0;
         masking_on_ff <= 1'b0;
      end else begin
         held_key_ff   <= held_key_in;
         key_idx_ff    <= key_idx_in;
         masking_on_ff <= masking_on_in;
      end
   end

endmodule

>>> hdl/wsfs_queue.sv
`timescale 1ns / 1ps
module wsfs_queue
   import wsfs_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  wsfs_entry_type        push_entry,
   input  logic                  pop,
   output wsfs_entry_type        head_entry,
   output wsfs_queue_status_type status
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   wsfs_entry_type slot_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_entry   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hdl/wsfs_back.sv
`timescale 1ns / 1ps
module wsfs_back
   import wsfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  wsfs_entry_type        head_entry,
   input  wsfs_queue_status_type q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_run_last,
   output logic                  rsp_frame_end
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;
   logic [7:0]        byte_ff, byte_in;
   logic              run_last_ff, run_last_in;
   logic              frame_end_ff, frame_end_in;
   logic              out_free;
   logic              emit;
   logic              at_last;

   assign out_free = !valid_ff || !rsp_stall;
   assign emit     = out_free && !q_status.empty;
   assign at_last  = (step_ff == head_entry.last_idx);
   assign pop      = emit && at_last;

   always_comb begin
      step_in      = step_ff;
      valid_in     = valid_ff;
      byte_in      = byte_ff;
      run_last_in  = run_last_ff;
      frame_end_in = frame_end_ff;
      if (emit) begin
         valid_in     = 1'b1;
         byte_in      = head_entry.bytes[step_ff];
         run_last_in  = at_last;
         frame_end_in = at_last && head_entry.frame_end;
         step_in      = at_last ? '0 : step_ff + 1'b1;
      end else if (out_free) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      run_last_ff  <= run_last_in;
      frame_end_ff <= frame_end_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_run_last  = run_last_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

>>> hdl/websocket_frame_serializer.sv
`timescale 1ns / 1ps
// an accepted item goes into a queue slot; its bytes leave via the output register
// one output byte per cycle from the single output register while rsp_stall is low
//   and the queue is not empty; a payload item is 1 byte, a header 2 to 14 bytes
// the queue of QUEUE_DEPTH items lets the input keep accepting while a header drains
// synchronous active-high reset clears key state, queue and output valid
module websocket_frame_serializer
   import wsfs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic        req_fin_bit,
   input  logic [2:0]  req_rsv_bits,
   input  logic [3:0]  req_frame_opcode,
   input  logic [6:0]  req_length_code,
   input  logic        req_mask_enable,
   input  logic [31:0] req_mask_key,
   input  logic [63:0] req_payload_length,
   input  logic [7:0]  req_payload_byte,
   input  logic        req_payload_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_frame_end
);

   wsfs_queue_status_type q_status;
   wsfs_entry_type        push_entry;
   wsfs_entry_type        head_entry;
   logic                  push;
   logic                  pop;

   wsfs_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_fin_bit        (req_fin_bit),
      .req_rsv_bits       (req_rsv_bits),
      .req_frame_opcode   (req_frame_opcode),
      .req_length_code    (req_length_code),
      .req_mask_enable    (req_mask_enable),
      .req_mask_key       (req_mask_key),
      .req_payload_length (req_payload_length),
      .req_payload_byte   (req_payload_byte),
      .req_payload_last   (req_payload_last),
      .q_status           (q_status),
      .push               (push),
      .push_entry         (push_entry)
   );

   wsfs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   wsfs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_entry    (head_entry),
      .q_status      (q_status),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

>>> dv/tb_websocket_frame_serializer.sv
`timescale 1ns / 1ps
module tb_websocket_frame_serializer
   import wsfs_pkg::*;
();

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 24;

   typedef struct packed {
      logic        kind;
      logic        fin;
      logic [2:0]  rsv;
      logic [3:0]  opcode;
      logic [6:0]  hdr_len;
      logic        mask_on;
      logic [31:0] key;
      logic [63:0] plen;
      logic [7:0]  data;
      logic        data_last;
   } frame_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_end;
   } frame_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = 1'b0;
   logic        req_fin_bit = 1'b0;
   logic [2:0]  req_rsv_bits = '0;
   logic [3:0]  req_frame_opcode = '0;
   logic [6:0]  req_length_code = '0;
   logic        req_mask_enable = 1'b0;
   logic [31:0] req_mask_key = '0;
   logic [63:0] req_payload_length = '0;
   logic [7:0]  req_payload_byte = '0;
   logic        req_payload_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_frame_end;

   // predicted frame state
   logic [31:0] frame_key = '0;
   logic [1:0]  key_index = '0;
   logic        frame_masked = 1'b0;

   frame_byte_type expected_bytes[$];
   int          errors = 0;
   int          cycle_count = 0;
   int          hold_left = 0;
   int          stall_burst = 0;
   bit          tx_idle_on = 1'b1;
   bit          rx_idle_on = 1'b1;

   websocket_frame_serializer DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_fin_bit        (req_fin_bit),
      .req_rsv_bits       (req_rsv_bits),
      .req_frame_opcode   (req_frame_opcode),
      .req_length_code    (req_length_code),
      .req_mask_enable    (req_mask_enable),
      .req_mask_key       (req_mask_key),
      .req_payload_length (req_payload_length),
      .req_payload_byte   (req_payload_byte),
      .req_payload_last   (req_payload_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_run_last       (rsp_run_last),
      .rsp_frame_end      (rsp_frame_end)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver: long hold-off when requested, else random stall bursts while rx_idle_on is set
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (stall_burst > 0) begin
         rsp_stall <= 1'b1;
         stall_burst--;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
         stall_burst = int'($urandom_range(1, 8)) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void predict_frame_bytes(frame_req_type r);
      logic [7:0] run [HDR_MAX_BYTES];
      int         n;
      logic [7:0] b;
      frame_byte_type e;
      n = 0;
      if (r.kind == REQ_HEADER) begin
         run[n++] = {r.fin, r.rsv, r.opcode};
         run[n++] = {r.mask_on, r.hdr_len};
         if (r.hdr_len == LEN_CODE_16) begin
            run[n++] = r.plen[15:8];
            run[n++] = r.plen[7:0];
         end else if (r.hdr_len == LEN_CODE_64) begin
            for (int i = 7; i >= 0; i--) run[n++] = r.plen[i*8 +: 8];
         end
         if (r.mask_on) begin
            for (int i = 3; i >= 0; i--) run[n++] = r.key[i*8 +: 8];
         end
         for (int i = 0; i < n; i++) begin
            e.out_byte  = run[i];
            e.run_last  = (i == n - 1);
            e.frame_end = 1'b0;
            expected_bytes.insert(expected_bytes.size(), e);
         end
         frame_key    = r.key;
         key_index    = '0;
         frame_masked = r.mask_on;
      end else begin
         b = r.data;
         if (frame_masked) begin
            b = b ^ frame_key[(3 - key_index)*8 +: 8];
            key_index = key_index + 2'd1;
         end
         e.out_byte  = b;
         e.run_last  = 1'b1;
         e.frame_end = r.data_last;
         expected_bytes.insert(expected_bytes.size(), e);
      end
   endfunction

   always @(posedge clock) begin : check_bytes
      frame_byte_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected byte: out_byte actual %0h", rsp_out_byte);
            errors++;
         end else begin
            e = expected_bytes.pop_front();
            if (rsp_out_byte !== e.out_byte) begin
               $error("out_byte expected %0h actual %0h", e.out_byte, rsp_out_byte);
               errors++;
            end
            if (rsp_run_last !== e.run_last) begin
               $error("run_last expected %0b actual %0b", e.run_last, rsp_run_last);
               errors++;
            end
            if (rsp_frame_end !== e.frame_end) begin
               $error("frame_end expected %0b actual %0b", e.frame_end, rsp_frame_end);
               errors++;
            end
         end
      end
   end

   function automatic frame_req_type random_req(logic kind);
      frame_req_type r;
      r.kind      = kind;
      r.fin       = 1'($urandom_range(0, 1));
      r.rsv       = 3'($urandom_range(0, 7));
      r.opcode    = 4'($urandom_range(0, 15));
      r.hdr_len   = 7'($urandom_range(0, 127));
      r.mask_on   = 1'($urandom_range(0, 1));
      r.key       = $urandom;
      r.plen      = {$urandom, $urandom};
      r.data      = 8'($urandom_range(0, 255));
      r.data_last = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic frame_req_type header_req(logic fin, logic [2:0] rsv, logic [3:0] opcode,
                                                logic [6:0] hdr_len, logic mask_on,
                                                logic [31:0] key, logic [63:0] plen);
      frame_req_type r;
      r = random_req(REQ_HEADER);
      r.fin      = fin;
      r.rsv      = rsv;
      r.opcode   = opcode;
      r.hdr_len  = hdr_len;
      r.mask_on  = mask_on;
      r.key      = key;
      r.plen     = plen;
      return r;
   endfunction

   function automatic frame_req_type payload_req(logic [7:0] data, logic data_last);
      frame_req_type r;
      r = random_req(REQ_PAYLOAD);
      r.data      = data;
      r.data_last = data_last;
      return r;
   endfunction

   task automatic send_item(frame_req_type r);
      req_type           <= r.kind;
      req_fin_bit        <= r.fin;
      req_rsv_bits       <= r.rsv;
      req_frame_opcode   <= r.opcode;
      req_length_code    <= r.hdr_len;
      req_mask_enable    <= r.mask_on;
      req_mask_key       <= r.key;
      req_payload_length <= r.plen;
      req_payload_byte   <= r.data;
      req_payload_last   <= r.data_last;
      req_valid          <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_frame_bytes(r);
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic test_payload_after_reset();
      send_item(payload_req(8'hA5, 1'b0));
      send_item(payload_req(8'hFF, 1'b1));
   endtask

   task automatic test_header_lengths();
      send_item(header_req(1'b1, 3'd7, 4'hF, 7'd0, 1'b0, 32'h0, 64'h0));
      send_item(header_req(1'b0, 3'd0, 4'h0, 7'd125, 1'b1, 32'hFFFF_FFFF, '1));
      send_item(header_req(1'b1, 3'd5, 4'h1, LEN_CODE_16, 1'b0, 32'h0, 64'h0123_4567_89AB_CDEF));
      send_item(header_req(1'b0, 3'd2, 4'h8, LEN_CODE_16, 1'b1, 32'h1234_5678, '1));
      send_item(header_req(1'b1, 3'd1, 4'h2, LEN_CODE_64, 1'b0, 32'h0, '1));
      send_item(header_req(1'b1, 3'd6, 4'h9, LEN_CODE_64, 1'b1, 32'hDEAD_BEEF,
                           64'hFEDC_BA98_7654_3210));
      send_item(header_req(1'b0, 3'd4, 4'hA, LEN_CODE_64, 1'b1, 32'h0, 64'h0));
      send_item(header_req(1'b1, 3'd3, 4'h0, 7'd127 - 7'd126, 1'b1, 32'h8000_0001, 64'h0));
   endtask

   // key rotation wraps and continues past the last byte of the frame
   task automatic test_masked_rotation();
      send_item(header_req(1'b1, 3'd0, 4'h2, 7'd6, 1'b1, 32'hC3A5_5A3C, 64'd6));
      for (int i = 0; i < 6; i++) send_item(payload_req(8'(i * 37), i == 5));
      send_item(payload_req(8'h00, 1'b0));
      send_item(header_req(1'b1, 3'd0, 4'h1, 7'd1, 1'b0, 32'hFFFF_FFFF, 64'd1));
      send_item(payload_req(8'h5A, 1'b1));
   endtask

   task automatic send_random_frame(ref int sent);
      frame_req_type r;
      int         n;
      r = random_req(REQ_HEADER);
      case ($urandom_range(0, 3))
         0: r.hdr_len = LEN_CODE_16;
         1: r.hdr_len = LEN_CODE_64;
         2: r.hdr_len = 7'($urandom_range(0, 125));
         default: ;
      endcase
      send_item(r);
      sent++;
      n = int'($urandom_range(0, 10));
      for (int i = 0; i < n; i++) begin
         r = random_req(REQ_PAYLOAD);
         r.data_last = (i == n - 1);
         send_item(r);
         sent++;
      end
      if ($urandom_range(0, 7) == 0) begin
         send_item(random_req(REQ_PAYLOAD));
         sent++;
      end
   endtask

   task automatic test_backpressure();
      int sent;
      sent = 0;
      hold_left = 200;
      while (sent < 40) send_random_frame(sent);
   endtask

   task automatic test_random_frames(int n_items);
      int sent;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 6) == 0) begin
            send_item(random_req(1'($urandom_range(0, 1))));
            sent++;
         end else begin
            send_random_frame(sent);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_payload_after_reset();
      test_header_lengths();
      test_masked_rotation();
      test_backpressure();
      test_random_frames(50);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      test_random_frames(30);
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      test_random_frames(30);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      test_random_frames(40);
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_bytes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/wsfs_pkg.sv
hdl/wsfs_front.sv
hdl/wsfs_queue.sv
hdl/wsfs_back.sv
hdl/websocket_frame_serializer.sv
dv/tb_websocket_frame_serializer.sv
